// ----- src/bdpt_pkg.sv -----
// Package for the push-button debouncer with press timer.
// Request/result payload structs, event and check codes, register indexes.
// No dependencies.
`default_nettype none

package bdpt_pkg;

  localparam int unsigned RunMax  = 15;
  localparam int unsigned HoldMax = 255;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    CHK_NONE     = 2'd0,
    CHK_EDGE     = 2'd1,
    CHK_ACTIVE   = 2'd2,
    CHK_INACTIVE = 2'd3
  } chk_t;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] REG_PRESSED_LEVEL      = 2'd0;
  localparam logic [1:0] REG_ACTIVE_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_INACTIVE_THRESHOLD = 2'd2;

  typedef struct packed {
    logic req_type;
    logic pin_level;
  } req_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] press_duration;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/button_debounce_press_timer.sv -----
// Top level of the push-button debouncer with press timer.
// Uses bdpt_pkg for payload structs and codes.
//
//   channel | direction | handshake        | payload
//   in      | request   | in_valid/in_stall | req_t  (req_type, pin_level)
//   out     | result    | out_valid/out_stall | rsp_t (event_kind, press_duration)
//   cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; state updates at the accepting edge.
// A read request's result appears in the output register the next cycle.
// A second result while the output is stalled goes to a skid register;
// in_stall rises only while the skid register is full.
// Synchronous reset; cfg_ready is always high.
`default_nettype none

module button_debounce_press_timer import bdpt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rsp_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic       pressed_level;
  logic [3:0] active_threshold;
  logic [3:0] inactive_threshold;

  logic       is_pressed_mode, is_pressed_mode_next;
  logic       stable_flag, stable_flag_next;
  logic       watch_level, watch_level_next;
  logic       previous_level, previous_level_next;
  logic [3:0] active_run, active_run_next;
  logic [3:0] inactive_run, inactive_run_next;
  logic [7:0] hold_count, hold_count_next;
  event_t     pending_event, pending_event_next;

  logic       skid_valid;
  rsp_t       skid_data;
  rsp_t       rsp_new;
  logic       accept, push, pop;
  chk_t       chk;
  logic [3:0] run_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (in_data.req_type == REQ_READ);
  assign pop       = out_valid && !out_stall;

  assign rsp_new.event_kind     = pending_event;
  assign rsp_new.press_duration = (pending_event == EV_RELEASED) ? hold_count : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level      <= 1'b0;
      active_threshold   <= 4'd5;
      inactive_threshold <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESSED_LEVEL:      pressed_level      <= cfg_data[0];
        REG_ACTIVE_THRESHOLD:   active_threshold   <= cfg_data;
        REG_INACTIVE_THRESHOLD: inactive_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_pressed_mode_next = is_pressed_mode;
    stable_flag_next     = stable_flag;
    watch_level_next     = watch_level;
    previous_level_next  = previous_level;
    active_run_next      = active_run;
    inactive_run_next    = inactive_run;
    hold_count_next      = hold_count;
    pending_event_next   = pending_event;
    chk                  = CHK_NONE;
    run_inc              = 4'd0;
    if (accept) begin
      if (in_data.req_type == REQ_READ) begin
        pending_event_next = EV_NONE;
      end else begin
        previous_level_next = in_data.pin_level;
        if (stable_flag) begin
          if (in_data.pin_level == watch_level && previous_level != watch_level) begin
            chk               = CHK_EDGE;
            active_run_next   = 4'd0;
            inactive_run_next = 4'd0;
            stable_flag_next  = 1'b0;
          end
        end else if (in_data.pin_level == watch_level) begin
          run_inc           = (active_run == 4'(RunMax)) ? active_run : active_run + 4'd1;
          inactive_run_next = 4'd0;
          active_run_next   = run_inc;
          if (run_inc >= active_threshold) begin
            stable_flag_next = 1'b1;
            chk              = CHK_ACTIVE;
          end
        end else begin
          run_inc           = (inactive_run == 4'(RunMax)) ? inactive_run : inactive_run + 4'd1;
          active_run_next   = 4'd0;
          inactive_run_next = run_inc;
          if (run_inc >= inactive_threshold) begin
            stable_flag_next = 1'b1;
            chk              = CHK_INACTIVE;
          end
        end

        if (!is_pressed_mode) begin
          if (chk == CHK_EDGE) begin
            pending_event_next   = EV_PRESSED;
            hold_count_next      = 8'd0;
            is_pressed_mode_next = 1'b1;
          end
        end else begin
          unique case (chk)
            CHK_NONE: begin
              if (hold_count != 8'(HoldMax)) hold_count_next = hold_count + 8'd1;
            end
            CHK_ACTIVE: begin
              watch_level_next = ~watch_level;
            end
            CHK_INACTIVE: begin
              watch_level_next     = pressed_level;
              is_pressed_mode_next = 1'b0;
            end
            CHK_EDGE: begin
              pending_event_next   = EV_RELEASED;
              watch_level_next     = pressed_level;
              is_pressed_mode_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed_mode <= 1'b0;
      stable_flag     <= 1'b1;
      watch_level     <= 1'b0;
      previous_level  <= 1'b1;
      active_run      <= 4'd0;
      inactive_run    <= 4'd0;
      hold_count      <= 8'd0;
      pending_event   <= EV_NONE;
    end else begin
      is_pressed_mode <= is_pressed_mode_next;
      stable_flag     <= stable_flag_next;
      watch_level     <= watch_level_next;
      previous_level  <= previous_level_next;
      active_run      <= active_run_next;
      inactive_run    <= inactive_run_next;
      hold_count      <= hold_count_next;
      pending_event   <= pending_event_next;
    end
  end

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || pop) out_data <= rsp_new;
      else                   skid_data <= rsp_new;
    end
  end

endmodule

`default_nettype wire

// ----- bench/button_debounce_press_timer_tb.sv -----
`timescale 1ns / 1ps
// Testbench for button_debounce_press_timer: a directed table, then random press/release
// trains with reads, checked against the table's results where it gives them, else an in-bench predictor.
// Depends on bdpt_pkg and the button_debounce_press_timer top level.

module button_debounce_press_timer_tb;
  import bdpt_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DirRows = 25;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] idx;
    logic [3:0] val;
    req_t       req;
    logic       typed;
    rsp_t       exp;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  button_debounce_press_timer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and debounce state
  logic       lvl_pressed = 1'b0;
  logic [3:0] thr_active = 4'd5;
  logic [3:0] thr_inactive = 4'd5;
  logic       in_press = 1'b0;
  logic       settled = 1'b1;
  logic       watch = 1'b0;
  logic       last_pin = 1'b1;
  logic [3:0] run_on = '0;
  logic [3:0] run_off = '0;
  logic [7:0] held = '0;
  event_t     latched = EV_NONE;

  rsp_t       event_reports_q [$];
  rsp_t       want;
  rsp_t       predicted;
  logic       row_typed = 1'b0;
  rsp_t       row_exp = '0;
  bit         gaps_on = 1'b1;
  dir_row_t   dir_rows [DirRows];

  int n_mismatch = 0;
  int n_sent = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_released = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               event_reports_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch @%0t: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    n_mismatch++;
  endtask

  task automatic debounce_tick(input logic pin);
    chk_t ck;
    ck = CHK_NONE;
    if (settled) begin
      if (pin == watch && last_pin != watch) begin
        ck = CHK_EDGE;
        run_on = '0;
        run_off = '0;
        settled = 1'b0;
      end
    end else if (pin == watch) begin
      run_off = '0;
      if (run_on != 4'(RunMax)) run_on = run_on + 4'd1;
      if (run_on >= thr_active) begin
        settled = 1'b1;
        ck = CHK_ACTIVE;
      end
    end else begin
      run_on = '0;
      if (run_off != 4'(RunMax)) run_off = run_off + 4'd1;
      if (run_off >= thr_inactive) begin
        settled = 1'b1;
        ck = CHK_INACTIVE;
      end
    end
    last_pin = pin;
    if (!in_press) begin
      if (ck == CHK_EDGE) begin
        latched = EV_PRESSED;
        held = '0;
        in_press = 1'b1;
      end
    end else begin
      case (ck)
        CHK_NONE: if (held != 8'(HoldMax)) held = held + 8'd1;
        CHK_ACTIVE: watch = ~watch;
        CHK_INACTIVE: begin
          watch = lvl_pressed;
          in_press = 1'b0;
        end
        default: begin
          latched = EV_RELEASED;
          watch = lvl_pressed;
          in_press = 1'b0;
        end
      endcase
    end
  endtask

  task automatic take_event(output rsp_t r);
    r.event_kind = latched;
    r.press_duration = (latched == EV_RELEASED) ? held : 8'd0;
    latched = EV_NONE;
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [3:0] val);
    case (idx)
      REG_PRESSED_LEVEL: lvl_pressed = val[0];
      REG_ACTIVE_THRESHOLD: thr_active = val;
      REG_INACTIVE_THRESHOLD: thr_inactive = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (event_reports_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data.event_kind, -1);
        end else begin
          want = event_reports_q.pop_front();
          if (out_data.event_kind !== want.event_kind)
            report_mismatch("event_kind", out_data.event_kind, want.event_kind);
          if (out_data.press_duration !== want.press_duration)
            report_mismatch("press_duration", out_data.press_duration, want.press_duration);
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_writes++;
      end
      if (in_valid && !in_stall) begin
        n_sent++;
        if (in_data.req_type == REQ_TICK) begin
          debounce_tick(in_data.pin_level);
          n_ticks++;
        end else begin
          take_event(predicted);
          if (predicted.event_kind == EV_RELEASED) n_released++;
          event_reports_q.push_back(row_typed ? row_exp : predicted);
          n_reads++;
        end
      end
    end
  end

  initial begin : out_stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic kind, input logic pin, input logic typed,
                          input rsp_t exp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req_t'{kind, pin};
    row_typed = typed;
    row_exp = exp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic step_tick(input logic pin);
    send_req(REQ_TICK, pin, 1'b0, '0);
    if ($urandom_range(0, 4) == 0) send_req(REQ_READ, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic bounce();
    repeat ($urandom_range(0, 3)) step_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic press_cycle(input int hold_len, input int rel_len);
    bounce();
    repeat (hold_len) step_tick(lvl_pressed);
    bounce();
    repeat (rel_len) step_tick(~lvl_pressed);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    in_valid <= 1'b0;
    while (event_reports_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic lvl, input logic [3:0] on_thr, input logic [3:0] off_thr);
    write_reg(REG_PRESSED_LEVEL, {3'($urandom_range(0, 7)), lvl});
    write_reg(REG_ACTIVE_THRESHOLD, on_thr);
    write_reg(REG_INACTIVE_THRESHOLD, off_thr);
  endtask

  task automatic run_phase(input int items, input bit long_press);
    int target;
    target = n_sent + items;
    if (long_press) press_cycle(270, 8);
    while (n_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10))
          send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if ($urandom_range(0, 19) == 0) begin
        press_cycle($urandom_range(0, 2), $urandom_range(0, 2));
      end else begin
        press_cycle($urandom_range(1, 40), $urandom_range(1, 25));
      end
    end
  endtask

  function automatic dir_row_t row_tick(input logic pin);
    row_tick = '{1'b0, 2'd0, 4'd0, req_t'{REQ_TICK, pin}, 1'b0, rsp_t'(0)};
  endfunction

  function automatic dir_row_t row_read();
    row_read = '{1'b0, 2'd0, 4'd0, req_t'{REQ_READ, 1'b0}, 1'b0, rsp_t'(0)};
  endfunction

  function automatic dir_row_t row_read_is(input event_t ev, input logic [7:0] dur);
    row_read_is = '{1'b0, 2'd0, 4'd0, req_t'{REQ_READ, 1'b1}, 1'b1, rsp_t'{ev, dur}};
  endfunction

  function automatic dir_row_t row_write(input logic [1:0] idx, input logic [3:0] val);
    row_write = '{1'b1, idx, val, req_t'(0), 1'b0, rsp_t'(0)};
  endfunction

  initial begin : stimulus
    int i;
    dir_rows = '{
      row_read_is(EV_NONE, 8'd0),
      row_tick(1'b1),
      row_tick(1'b0),                       // press edge
      row_read_is(EV_PRESSED, 8'd0),
      row_read_is(EV_NONE, 8'd0),           // read clears
      row_tick(1'b0), row_tick(1'b0), row_tick(1'b0), row_tick(1'b0), row_tick(1'b0),
      row_tick(1'b0),
      row_tick(1'b1),                       // release edge
      row_read(),
      row_write(REG_ACTIVE_THRESHOLD, 4'd0),
      row_write(REG_INACTIVE_THRESHOLD, 4'd15),
      row_write(REG_PRESSED_LEVEL, 4'hF),
      row_write(RegUnused, 4'h5),
      row_tick(1'b0), row_tick(1'b1), row_tick(1'b0), row_tick(1'b1),
      row_read(),
      row_write(REG_PRESSED_LEVEL, 4'hE),
      row_tick(1'b0),
      row_read()
    };

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DirRows; i++) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_req(dir_rows[i].req.req_type, dir_rows[i].req.pin_level,
                 dir_rows[i].typed, dir_rows[i].exp);
    end

    set_regs(1'b1, 4'd1, 4'd1);
    run_phase(300, 1'b1);
    set_regs(1'b0, 4'd15, 4'd15);
    run_phase(60, 1'b0);
    set_regs(1'b1, 4'd0, 4'd0);
    run_phase(50, 1'b0);
    set_regs(1'b0, 4'd3, 4'd7);
    run_phase(60, 1'b0);
    set_regs(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    write_reg(RegUnused, 4'($urandom_range(0, 15)));
    run_phase(60, 1'b0);
    set_regs(1'b1, 4'd15, 4'd1);
    gaps_on = 1'b0;
    run_phase(60, 1'b0);

    in_valid <= 1'b0;
    while (event_reports_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("ran %0d ticks and %0d reads over %0d register writes", n_ticks, n_reads,
             n_writes);
    $display("checked %0d event reports, %0d of them releases with a duration",
             n_results, n_released);
    if (n_mismatch == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
